/* rtl/core/ell_pkg.sv */
// Shared types, codes and constants of the extent leaf lookup block.
package ell_pkg;

    localparam int DEFAULT_MAX_ENTRIES = 512;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_INDEX_W = 2;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [1:0] ST_MAPPED = 2'd0;
    localparam logic [1:0] ST_HOLE   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;

    localparam logic [CFG_INDEX_W-1:0] REG_ENTRY_COUNT = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_FIRST = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_RANGE_LAST  = 2'd2;

    typedef struct packed {
        logic        op;
        logic [8:0]  entry_index;
        logic [31:0] ext_start_block;
        logic [15:0] ext_length;
        logic [47:0] ext_phys_block;
        logic [31:0] query_block;
    } cmd_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  found_index;
        logic [31:0] out_start_block;
        logic [31:0] out_length;
        logic [47:0] out_phys_block;
    } result_t;

    typedef struct packed {
        logic [9:0]  entry_count;
        logic [31:0] range_first;
        logic [31:0] range_last;
    } cfg_t;

    typedef struct packed {
        logic [31:0] start_block;
        logic [15:0] length;
        logic [47:0] phys_block;
    } entry_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_FOUND,
        S_NEXT
    } state_t;

endpackage

/* rtl/core/extent_leaf_lookup_unit.sv */
// Top level of the extent leaf lookup block: configuration registers and instances.
//
// Usage: an item is taken on cmd at a clock edge where start is high and busy is
// low. A load item (op = load) writes one table slot in that cycle, gives no
// result and leaves busy low, so loads may follow one per cycle. A query item
// raises busy and binary-searches the first entry_count slots of the table.
// Each search probe is one read of the single-port-read extent memory per
// cycle. The first probe is issued in the accepting cycle; the search then
// narrows a range over the first n slots, n being entry_count capped at
// MAX_ENTRIES, then reads the candidate extent, and also reads the next
// slot when the block lies in a gap. The next item can be taken in the
// result cycle. An empty leaf answers without raising busy. The result is
// shown on result for exactly one cycle with done high, in a cycle where busy
// is low; there is no back pressure, so the receiver must take it then.
// Configuration: cfg_we with cfg_index and cfg_wdata writes one register at once;
// write only while busy is low. Reset clears the registers and the sequencer;
// table contents are undefined until loaded.
module extent_leaf_lookup_unit #(
    parameter int MAX_ENTRIES = ell_pkg::DEFAULT_MAX_ENTRIES
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  ell_pkg::cmd_t                      cmd,
    output logic                               done,
    output ell_pkg::result_t                   result,
    input  logic                               cfg_we,
    input  logic [ell_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [ell_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import ell_pkg::*;

    localparam int AW = $clog2(MAX_ENTRIES);

    cfg_t          cfg_reg;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    entry_t        ram_rdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ENTRY_COUNT: cfg_reg.entry_count <= cfg_wdata[9:0];
                REG_RANGE_FIRST: cfg_reg.range_first <= cfg_wdata;
                REG_RANGE_LAST:  cfg_reg.range_last <= cfg_wdata;
                default:         cfg_reg <= cfg_reg;
            endcase
        end
    end

    ell_search_ctrl #(
        .MAX_ENTRIES(MAX_ENTRIES),
        .AW(AW)
    ) u_ctrl (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .cmd(cmd),
        .cfg(cfg_reg),
        .done(done),
        .result(result),
        .ram_we(ram_we),
        .ram_waddr(ram_waddr),
        .ram_wdata(ram_wdata),
        .ram_re(ram_re),
        .ram_raddr(ram_raddr),
        .ram_rdata(ram_rdata)
    );

    ell_entry_ram #(
        .DEPTH(MAX_ENTRIES),
        .AW(AW)
    ) u_ram (
        .clk(clk),
        .we(ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .re(ram_re),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

endmodule

/* rtl/core/ell_entry_ram.sv */
// Extent table memory: one write port, one read port with registered read data.
module ell_entry_ram #(
    parameter int DEPTH = ell_pkg::DEFAULT_MAX_ENTRIES,
    parameter int AW = $clog2(DEPTH)
) (
    input  logic            clk,
    input  logic            we,
    input  logic [AW-1:0]   waddr,
    input  ell_pkg::entry_t wdata,
    input  logic            re,
    input  logic [AW-1:0]   raddr,
    output ell_pkg::entry_t rdata
);
    import ell_pkg::*;

    entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* rtl/core/ell_search_ctrl.sv */
// Sequencer: table loads, binary search probes and hole calculation.
module ell_search_ctrl #(
    parameter int MAX_ENTRIES = ell_pkg::DEFAULT_MAX_ENTRIES,
    parameter int AW = $clog2(MAX_ENTRIES)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  ell_pkg::cmd_t    cmd,
    input  ell_pkg::cfg_t    cfg,
    output logic             done,
    output ell_pkg::result_t result,
    output logic             ram_we,
    output logic [AW-1:0]    ram_waddr,
    output ell_pkg::entry_t  ram_wdata,
    output logic             ram_re,
    output logic [AW-1:0]    ram_raddr,
    input  ell_pkg::entry_t  ram_rdata
);
    import ell_pkg::*;

    localparam int CW = $clog2(MAX_ENTRIES + 1);
    localparam int XW = (CW > 10) ? CW : 10;
    localparam int SW = (AW > 9) ? AW + 1 : 10;

    state_t        state_reg, state_next;
    logic [CW-1:0] lo_reg, lo_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [AW-1:0] mid_reg, mid_next;
    logic [31:0]   q_reg, q_next;
    logic [31:0]   hole_reg, hole_next;
    logic          done_reg, done_next;
    result_t       result_reg, result_next;

    logic [XW-1:0] count_ext;
    logic [CW-1:0] n;
    logic [SW-1:0] slot_ext;
    logic          slot_ok;
    logic          q_ge;
    logic [CW-1:0] mid_up;
    logic [CW-1:0] mid_if_ge;
    logic [CW-1:0] mid_if_lt;
    logic [CW-1:0] lo_sel;
    logic [CW-1:0] hi_sel;
    logic [32:0]   ext_end;

    // Midpoint of a half-open range [a, b), matching lo + (hi - lo) / 2 on inclusive hi.
    function automatic logic [CW-1:0] mid_of(input logic [CW-1:0] a, input logic [CW-1:0] b);
        logic [CW-1:0] span;
        begin
            span = b - a - CW'(1);
            mid_of = a + (span >> 1);
        end
    endfunction

    assign count_ext = XW'(cfg.entry_count);
    assign n = (count_ext > XW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : CW'(count_ext);

    assign slot_ext = SW'(cmd.entry_index);
    assign slot_ok = slot_ext < SW'(MAX_ENTRIES);

    // Both possible next midpoints are formed in parallel; the compare only selects.
    assign q_ge = !(q_reg < ram_rdata.start_block);
    assign mid_up = CW'(mid_reg) + CW'(1);
    assign lo_sel = q_ge ? mid_up : lo_reg;
    assign hi_sel = q_ge ? hi_reg : CW'(mid_reg);
    assign mid_if_ge = mid_of(mid_up, hi_reg);
    assign mid_if_lt = mid_of(lo_reg, CW'(mid_reg));

    assign ext_end = {1'b0, ram_rdata.start_block} + 33'(ram_rdata.length);

    assign ram_waddr = AW'(slot_ext);
    assign ram_wdata.start_block = cmd.ext_start_block;
    assign ram_wdata.length = cmd.ext_length;
    assign ram_wdata.phys_block = cmd.ext_phys_block;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lo_reg <= lo_next;
        hi_reg <= hi_next;
        mid_reg <= mid_next;
        q_reg <= q_next;
        hole_reg <= hole_next;
        result_reg <= result_next;
    end

    always_comb
    begin
        state_next = state_reg;
        lo_next = lo_reg;
        hi_next = hi_reg;
        mid_next = mid_reg;
        q_next = q_reg;
        hole_next = hole_reg;
        done_next = 1'b0;
        result_next = result_reg;
        ram_we = 1'b0;
        ram_re = 1'b0;
        ram_raddr = mid_reg;
        busy = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    if (cmd.op == OP_LOAD)
                    begin
                        ram_we = slot_ok;
                    end
                    else if (n == '0)
                    begin
                        done_next = 1'b1;
                        result_next = '0;
                        result_next.status = ST_EMPTY;
                    end
                    else
                    begin
                        q_next = cmd.query_block;
                        lo_next = '0;
                        hi_next = n;
                        mid_next = AW'(mid_of('0, n));
                        ram_re = 1'b1;
                        ram_raddr = mid_next;
                        state_next = S_SEARCH;
                    end
                end
            end

            S_SEARCH:
            begin
                lo_next = lo_sel;
                hi_next = hi_sel;
                ram_re = 1'b1;
                if (lo_sel < hi_sel)
                begin
                    mid_next = q_ge ? AW'(mid_if_ge) : AW'(mid_if_lt);
                    ram_raddr = mid_next;
                end
                else
                begin
                    // Search has ended: fetch the candidate extent, or slot 0 for a
                    // query that lies before every extent.
                    ram_raddr = (lo_sel == '0) ? '0 : AW'(lo_sel - CW'(1));
                    state_next = S_FOUND;
                end
            end

            S_FOUND:
            begin
                result_next = '0;
                if (lo_reg == '0)
                begin
                    done_next = 1'b1;
                    result_next.status = ST_HOLE;
                    result_next.out_start_block = cfg.range_first;
                    result_next.out_length = ram_rdata.start_block - cfg.range_first;
                    state_next = S_IDLE;
                end
                else if (ext_end > {1'b0, q_reg})
                begin
                    done_next = 1'b1;
                    result_next.status = ST_MAPPED;
                    result_next.found_index = 9'(lo_reg - CW'(1));
                    result_next.out_start_block = ram_rdata.start_block;
                    result_next.out_length = 32'(ram_rdata.length);
                    result_next.out_phys_block = ram_rdata.phys_block;
                    state_next = S_IDLE;
                end
                else if (lo_reg < n)
                begin
                    // Gap: the hole runs up to the start of the following slot.
                    hole_next = ext_end[31:0];
                    ram_re = 1'b1;
                    ram_raddr = AW'(lo_reg);
                    state_next = S_NEXT;
                end
                else
                begin
                    done_next = 1'b1;
                    result_next.status = ST_HOLE;
                    result_next.out_start_block = ext_end[31:0];
                    result_next.out_length = cfg.range_last - ext_end[31:0] + 32'd1;
                    state_next = S_IDLE;
                end
            end

            S_NEXT:
            begin
                done_next = 1'b1;
                result_next = '0;
                result_next.status = ST_HOLE;
                result_next.out_start_block = hole_reg;
                result_next.out_length = ram_rdata.start_block - hole_reg;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign done = done_reg;
    assign result = result_reg;

    a_search_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |-> lo_reg < hi_reg && hi_reg <= n)
        else $error("search range is empty or beyond the entry count");

    a_mid_inside: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SEARCH |-> CW'(mid_reg) >= lo_reg && CW'(mid_reg) < hi_reg)
        else $error("probe slot lies outside the search range");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> state_reg == S_IDLE && !ram_re)
        else $error("table write outside idle or together with a read");

    a_done_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(done_reg) |-> $past(state_reg != S_IDLE || (start && cmd.op == OP_QUERY)))
        else $error("result issued without a query");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> state_reg == S_IDLE && !busy)
        else $error("result issued while a search is running");

endmodule
